>>> rtl/core/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and codes for the shelf rectangle allocator.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int unsigned COORD_W = 13;

    // handle table depth, fixed by the 6-bit handle ports
    localparam int MAX_ALLOCS = 64;

    // operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd3;
    localparam logic [2:0] ST_FREE_FULL  = 3'd4;

    // register word indexes
    localparam logic [1:0] REG_ATLAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GAP_MARGIN   = 2'd2;

    localparam logic [12:0] ATLAS_W_RESET = 13'd4096;
    localparam logic [12:0] ATLAS_H_RESET = 13'd4096;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } box_t;

endpackage

>>> rtl/core/shelf_rectangle_allocator_unit.sv
// ----------------------------------------------------------------------------
// shelf_rectangle_allocator_unit
// Row based rectangle allocator for a 2-D atlas with a first-fit free list.
// ----------------------------------------------------------------------------
// Usage: a request (op, req_width, req_height, handle_in) is taken on the
// input channel when in_valid is high and in_stall low. Every request gives
// exactly one response (status, rect_x, rect_y, handle_out, alloc_count) on
// the output channel, taken when out_valid is high and out_stall low.
// in_stall stays high while a request is being worked on; one request at a
// time. An allocate scans for the lowest free handle, then tries the current
// row, then a new row, then the free list, first fit, closing the gap left
// by the taken entry through one memory port. The next request is taken once
// the response is loaded. Reset empties both tables and puts the rover at the
// origin; the registers go to 4096 x 4096 with no margin. While out_stall
// holds the response, the block still takes the next request and holds its
// response until the output register frees up. Configuration is written over
// the APB port; the user must write it only while the block is idle, as the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module shelf_rectangle_allocator_unit #(
    parameter int FREE_DEPTH     = 16,
    parameter int MIN_TAIL_WIDTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [12:0] req_width,
    input  logic [12:0] req_height,
    input  logic [5:0]  handle_in,
    // response channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [12:0] rect_x,
    output logic [12:0] rect_y,
    output logic [5:0]  handle_out,
    output logic [6:0]  alloc_count
);
    import sra_pkg::*;

    localparam int IW  = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
    localparam int CW  = $clog2(MAX_ALLOCS + 1);
    localparam int FIW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int FW  = $clog2(FREE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SLOT, S_AH, S_AV, S_FITW, S_FITH, S_RH,
        S_NR_V, S_NR_W1, S_NR_W2, S_TAIL_W, S_TAIL_H,
        S_RU_RD, S_RU_CHK, S_SH_RD, S_SH_WR, S_COMMIT,
        S_REL_RD, S_REL_WR, S_OUT
    } state_t;

    // configuration registers
    logic [12:0] atlas_w_reg, atlas_h_reg;
    logic [7:0]  margin_reg;

    state_t state_reg;
    logic [1:0]  op_reg;
    logic [12:0] w_reg, h_reg;
    logic [5:0]  hin_reg;
    logic [12:0] rx_reg, ry_reg, rh_reg;
    logic [15:0] ah_reg, av_reg, tmp_reg;
    logic        fitw_reg, nrv_reg, tw_reg;
    logic [IW-1:0] slot_reg;
    logic [FW-1:0] fc_reg, idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [MAX_ALLOCS-1:0] valid_reg;
    logic [2:0]  st_reg;
    logic [12:0] px_reg, py_reg;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [12:0] out_x_reg, out_y_reg;
    logic [5:0]  out_h_reg;
    logic [6:0]  out_cnt_reg;

    // memories
    box_t free_mem [FREE_DEPTH];
    box_t alloc_mem [MAX_ALLOCS];
    box_t fm_rd_reg, am_rd_reg;
    logic          fm_we;
    logic [FIW-1:0] fm_waddr, fm_raddr;
    box_t          fm_wdata;
    logic          am_we;
    box_t          am_wdata;
    logic [IW-1:0] am_raddr;

    // shared subtract unit: a - b - c
    logic signed [15:0] alu_a, alu_b, alu_c, alu_res;
    logic               alu_neg;

    logic [FW:0] idx_p1, idx_p2;
    logic        apb_wr;
    logic        hin_bad;
    box_t        tail_box;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;
    assign in_stall = (state_reg != S_IDLE);

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign rect_x      = out_x_reg;
    assign rect_y      = out_y_reg;
    assign handle_out  = out_h_reg;
    assign alloc_count = out_cnt_reg;

    assign idx_p1  = {1'b0, idx_reg} + (FW+1)'(1);
    assign idx_p2  = {1'b0, idx_reg} + (FW+1)'(2);
    assign hin_bad = (32'(hin_reg) >= 32'(MAX_ALLOCS)) || !valid_reg[IW'(hin_reg)];

    // register read
    always_comb
    begin
        unique case (paddr[3:2])
            REG_ATLAS_WIDTH:  prdata = {19'd0, atlas_w_reg};
            REG_ATLAS_HEIGHT: prdata = {19'd0, atlas_h_reg};
            REG_GAP_MARGIN:   prdata = {24'd0, margin_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_w_reg <= ATLAS_W_RESET;
            atlas_h_reg <= ATLAS_H_RESET;
            margin_reg  <= 8'd0;
        end
        else if (apb_wr && pready)
        begin
            unique case (paddr[3:2])
                REG_ATLAS_WIDTH:  atlas_w_reg <= pwdata[12:0];
                REG_ATLAS_HEIGHT: atlas_h_reg <= pwdata[12:0];
                REG_GAP_MARGIN:   margin_reg  <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    // operand selection for the subtract unit
    always_comb
    begin
        alu_a = 16'sd0;
        alu_b = 16'sd0;
        alu_c = 16'sd0;
        unique case (state_reg)
            S_AH:
            begin
                alu_a = 16'(atlas_w_reg); alu_b = 16'(rx_reg); alu_c = 16'(margin_reg);
            end
            S_AV:
            begin
                alu_a = 16'(atlas_h_reg); alu_b = 16'(ry_reg); alu_c = 16'(margin_reg);
            end
            S_FITW:
            begin
                alu_a = ah_reg; alu_b = 16'(w_reg);
            end
            S_FITH:
            begin
                alu_a = av_reg; alu_b = 16'(h_reg);
            end
            S_RH:
            begin
                alu_a = 16'(rh_reg); alu_b = 16'(h_reg); alu_c = 16'(margin_reg);
            end
            S_NR_V:
            begin
                alu_a = av_reg; alu_b = 16'(rh_reg); alu_c = 16'(h_reg);
            end
            S_NR_W1:
            begin
                alu_a = 16'(atlas_w_reg); alu_b = 16'(margin_reg); alu_c = 16'(margin_reg);
            end
            S_NR_W2:
            begin
                alu_a = tmp_reg; alu_b = 16'(w_reg);
            end
            S_TAIL_W:
            begin
                alu_a = ah_reg; alu_b = 16'(MIN_TAIL_WIDTH);
            end
            S_TAIL_H:
            begin
                alu_a = 16'(rh_reg); alu_b = 16'(margin_reg);
            end
            default: ;
        endcase
    end

    assign alu_res = alu_a - alu_b - alu_c;
    assign alu_neg = alu_res[15];

    // unused row tail to be logged
    always_comb
    begin
        tail_box.x = rx_reg;
        tail_box.y = ry_reg;
        tail_box.w = ah_reg[12:0];
        tail_box.h = alu_res[12:0];
    end

    // free list write port and read address
    always_comb
    begin
        fm_we    = 1'b0;
        fm_waddr = fc_reg[FIW-1:0];
        fm_wdata = tail_box;
        fm_raddr = idx_reg[FIW-1:0];
        unique case (state_reg)
            S_TAIL_H:
            begin
                fm_we = tw_reg && !alu_neg && (alu_res != 16'sd0)
                        && (32'(fc_reg) < 32'(FREE_DEPTH));
            end
            S_SH_RD:
            begin
                fm_raddr = FIW'(idx_p1);
            end
            S_SH_WR:
            begin
                fm_we    = 1'b1;
                fm_waddr = idx_reg[FIW-1:0];
                fm_wdata = fm_rd_reg;
            end
            S_REL_WR:
            begin
                fm_we    = (32'(fc_reg) < 32'(FREE_DEPTH));
                fm_wdata = am_rd_reg;
            end
            default: ;
        endcase
    end

    // allocation table write port and read address
    always_comb
    begin
        am_we      = (state_reg == S_COMMIT);
        am_wdata.x = px_reg;
        am_wdata.y = py_reg;
        am_wdata.w = w_reg;
        am_wdata.h = h_reg;
        am_raddr   = IW'(hin_reg);
    end

    // free list memory
    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            free_mem[fm_waddr] <= fm_wdata;
        end
        fm_rd_reg <= free_mem[fm_raddr];
    end

    // allocation table memory
    always_ff @(posedge clk)
    begin
        if (am_we)
        begin
            alloc_mem[slot_reg] <= am_wdata;
        end
        am_rd_reg <= alloc_mem[am_raddr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_NOP;
            w_reg          <= '0;
            h_reg          <= '0;
            hin_reg        <= '0;
            ah_reg         <= '0;
            av_reg         <= '0;
            tmp_reg        <= '0;
            fitw_reg       <= 1'b0;
            nrv_reg        <= 1'b0;
            tw_reg         <= 1'b0;
            slot_reg       <= '0;
            idx_reg        <= '0;
            st_reg         <= ST_OK;
            px_reg         <= '0;
            py_reg         <= '0;
            rx_reg         <= '0;
            ry_reg         <= '0;
            rh_reg         <= '0;
            fc_reg         <= '0;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_h_reg      <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg   <= op;
                        w_reg    <= req_width;
                        h_reg    <= req_height;
                        hin_reg  <= handle_in;
                        st_reg   <= ST_OK;
                        px_reg   <= '0;
                        py_reg   <= '0;
                        slot_reg <= '0;
                        idx_reg  <= '0;
                        unique case (op)
                            OP_ALLOC:   state_reg <= S_SLOT;
                            OP_RELEASE: state_reg <= S_REL_RD;
                            OP_CLEAR:
                            begin
                                valid_reg <= '0;
                                cnt_reg   <= '0;
                                fc_reg    <= '0;
                                rx_reg    <= 13'(margin_reg);
                                ry_reg    <= 13'(margin_reg);
                                rh_reg    <= '0;
                                state_reg <= S_OUT;
                            end
                            default:    state_reg <= S_OUT;
                        endcase
                    end
                end
                // lowest free handle, one slot a cycle
                S_SLOT:
                begin
                    if (!valid_reg[slot_reg])
                    begin
                        state_reg <= S_AH;
                    end
                    else if (32'(slot_reg) == 32'(MAX_ALLOCS - 1))
                    begin
                        st_reg    <= ST_TABLE_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + IW'(1);
                    end
                end
                S_AH:
                begin
                    ah_reg    <= alu_res;
                    state_reg <= S_AV;
                end
                S_AV:
                begin
                    av_reg    <= alu_res;
                    state_reg <= S_FITW;
                end
                S_FITW:
                begin
                    fitw_reg  <= !alu_neg;
                    state_reg <= S_FITH;
                end
                S_FITH:
                begin
                    state_reg <= (fitw_reg && !alu_neg) ? S_RH : S_NR_V;
                end
                // place on the current row
                S_RH:
                begin
                    if (alu_neg)
                    begin
                        rh_reg <= h_reg + 13'(margin_reg);
                    end
                    px_reg    <= rx_reg;
                    py_reg    <= ry_reg;
                    rx_reg    <= rx_reg + w_reg + 13'(margin_reg);
                    state_reg <= S_COMMIT;
                end
                S_NR_V:
                begin
                    nrv_reg   <= !alu_neg;
                    state_reg <= S_NR_W1;
                end
                S_NR_W1:
                begin
                    tmp_reg   <= alu_res;
                    state_reg <= S_NR_W2;
                end
                S_NR_W2:
                begin
                    if (nrv_reg && !alu_neg)
                    begin
                        state_reg <= S_TAIL_W;
                    end
                    else if (fc_reg != '0)
                    begin
                        state_reg <= S_RU_RD;
                    end
                    else
                    begin
                        st_reg    <= ST_NO_SPACE;
                        state_reg <= S_OUT;
                    end
                end
                S_TAIL_W:
                begin
                    tw_reg    <= !alu_neg;
                    state_reg <= S_TAIL_H;
                end
                // open a new row, logging the old tail
                S_TAIL_H:
                begin
                    if (fm_we)
                    begin
                        fc_reg <= fc_reg + FW'(1);
                    end
                    px_reg    <= 13'(margin_reg);
                    py_reg    <= ry_reg + rh_reg;
                    ry_reg    <= ry_reg + rh_reg;
                    rx_reg    <= 13'(margin_reg) + w_reg + 13'(margin_reg);
                    rh_reg    <= h_reg + 13'(margin_reg);
                    state_reg <= S_COMMIT;
                end
                // first-fit scan of the free list
                S_RU_RD:
                begin
                    state_reg <= S_RU_CHK;
                end
                S_RU_CHK:
                begin
                    if ((fm_rd_reg.w >= w_reg) && (fm_rd_reg.h >= h_reg))
                    begin
                        px_reg <= fm_rd_reg.x;
                        py_reg <= fm_rd_reg.y;
                        if (idx_p1 < {1'b0, fc_reg})
                        begin
                            state_reg <= S_SH_RD;
                        end
                        else
                        begin
                            fc_reg    <= fc_reg - FW'(1);
                            state_reg <= S_COMMIT;
                        end
                    end
                    else if (idx_p1 < {1'b0, fc_reg})
                    begin
                        idx_reg   <= FW'(idx_p1);
                        state_reg <= S_RU_RD;
                    end
                    else
                    begin
                        st_reg    <= ST_NO_SPACE;
                        state_reg <= S_OUT;
                    end
                end
                // close the gap left by the taken entry
                S_SH_RD:
                begin
                    state_reg <= S_SH_WR;
                end
                S_SH_WR:
                begin
                    idx_reg <= FW'(idx_p1);
                    if (idx_p2 < {1'b0, fc_reg})
                    begin
                        state_reg <= S_SH_RD;
                    end
                    else
                    begin
                        fc_reg    <= fc_reg - FW'(1);
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    cnt_reg             <= cnt_reg + CW'(1);
                    state_reg           <= S_OUT;
                end
                // release
                S_REL_RD:
                begin
                    if (hin_bad)
                    begin
                        st_reg    <= ST_BAD_HANDLE;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_REL_WR;
                    end
                end
                S_REL_WR:
                begin
                    if (fm_we)
                    begin
                        fc_reg <= fc_reg + FW'(1);
                    end
                    else
                    begin
                        st_reg <= ST_FREE_FULL;
                    end
                    valid_reg[IW'(hin_reg)] <= 1'b0;
                    cnt_reg                 <= cnt_reg - CW'(1);
                    state_reg               <= S_OUT;
                end
                // response register
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= st_reg;
                        out_x_reg      <= px_reg;
                        out_y_reg      <= py_reg;
                        out_h_reg      <= (op_reg == OP_ALLOC && st_reg == ST_OK)
                                          ? 6'(slot_reg) : 6'd0;
                        out_cnt_reg    <= 7'(cnt_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // live count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) == $countones(valid_reg))
        else $error("live count out of step with valid bits");

    // free list never overfills
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fc_reg) <= 32'(FREE_DEPTH))
        else $error("free list count beyond depth");

    // a commit always adds exactly one live allocation
    a_commit_adds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("commit did not add an allocation");

    // the response register is only loaded from the output step
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("response raised outside the output step");

endmodule

>>> verif/sra_checker.sv
// ----------------------------------------------------------------------------
// sra_checker
// Watches the request and response channels of the shelf allocator, keeps
// its own copy of the rover, free list and handle table, and compares each
// response with the predicted one.
// ----------------------------------------------------------------------------
module sra_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  op,
    input  logic [12:0] req_width,
    input  logic [12:0] req_height,
    input  logic [5:0]  handle_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [12:0] rect_x,
    input  logic [12:0] rect_y,
    input  logic [5:0]  handle_out,
    input  logic [6:0]  alloc_count,
    output int          fail_count,
    output int          pending,
    output int          resp_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import sra_pkg::*;

    localparam int FREE_SLOTS = 16;
    localparam int HANDLES    = MAX_ALLOCS;
    localparam int TAIL_MIN   = 8;

    typedef struct {
        logic [2:0]  st;
        logic [12:0] x;
        logic [12:0] y;
        logic [5:0]  hnd;
        logic [6:0]  live;
    } resp_t;

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } area_t;

    resp_t  expected_resp[$];
    int     atlas_w, atlas_h, margin;
    int     rov_x, rov_y, shelf_h;
    area_t  holes[$];
    bit     used[HANDLES];
    area_t  owned[HANDLES];

    assign pending = expected_resp.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void log_hole(input area_t a);
        if (holes.size() < FREE_SLOTS)
            holes.push_back(a);
    endfunction

    // place on the current shelf or open a new one below
    function automatic bit shelf_place(input int w, input int h, output area_t a);
        int avail_h;
        int avail_v;
        area_t tail;
        avail_h = atlas_w - rov_x - margin;
        avail_v = atlas_h - rov_y - margin;
        if (avail_h >= w && avail_v >= h) begin
            if (h + margin > shelf_h)
                shelf_h = h + margin;
        end
        else if (avail_v - shelf_h >= h && atlas_w - 2 * margin >= w) begin
            if (avail_h >= TAIL_MIN && shelf_h > margin) begin
                tail = '{rov_x, rov_y, avail_h, shelf_h - margin};
                log_hole(tail);
            end
            rov_x = margin;
            rov_y += shelf_h;
            shelf_h = h + margin;
        end
        else begin
            return 0;
        end
        a = '{rov_x, rov_y, w, h};
        rov_x += w + margin;
        return 1;
    endfunction

    // first fit over the logged holes, whole entry taken
    function automatic bit hole_place(input int w, input int h, output area_t a);
        foreach (holes[i]) begin
            if (holes[i].w >= w && holes[i].h >= h) begin
                a = '{holes[i].x, holes[i].y, w, h};
                holes.delete(i);
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic resp_t predict_response(input logic [1:0] o, input int w,
                                               input int h, input int hin);
        resp_t r;
        int    slot;
        int    n;
        area_t a;
        r = '{ST_OK, 0, 0, 0, 0};
        slot = -1;
        if (o == OP_ALLOC) begin
            for (int i = 0; i < HANDLES; i++)
                if (!used[i] && slot < 0)
                    slot = i;
            if (slot < 0)
                r.st = ST_TABLE_FULL;
            else if (shelf_place(w, h, a) || hole_place(w, h, a)) begin
                used[slot] = 1;
                owned[slot] = a;
                r.hnd = 6'(slot);
                r.x = 13'(a.x);
                r.y = 13'(a.y);
            end
            else
                r.st = ST_NO_SPACE;
        end
        else if (o == OP_RELEASE) begin
            if (!used[hin])
                r.st = ST_BAD_HANDLE;
            else begin
                if (holes.size() >= FREE_SLOTS)
                    r.st = ST_FREE_FULL;
                else
                    log_hole(owned[hin]);
                used[hin] = 0;
            end
        end
        else if (o == OP_CLEAR) begin
            foreach (used[i])
                used[i] = 0;
            holes.delete();
            rov_x = margin;
            rov_y = margin;
            shelf_h = 0;
        end
        n = 0;
        foreach (used[i])
            n += int'(used[i]);
        r.live = 7'(n);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        resp_t want;
        if (!rst_n) begin
            atlas_w = int'(ATLAS_W_RESET);
            atlas_h = int'(ATLAS_H_RESET);
            margin = 0;
            rov_x = 0;
            rov_y = 0;
            shelf_h = 0;
            holes.delete();
            foreach (used[i])
                used[i] = 0;
            expected_resp.delete();
            fail_count = 0;
            resp_seen = 0;
        end
        else begin
            // register writes
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_ATLAS_WIDTH:  atlas_w = int'(pwdata[12:0]);
                    REG_ATLAS_HEIGHT: atlas_h = int'(pwdata[12:0]);
                    REG_GAP_MARGIN:   margin = int'(pwdata[7:0]);
                    default: ;
                endcase
            end
            // responses
            if (out_valid && !out_stall) begin
                resp_seen++;
                if (expected_resp.size() == 0) begin
                    $display("response with nothing expected at %0t", $realtime);
                    fail_count++;
                end
                else begin
                    want = expected_resp.pop_front();
                    if (status !== want.st)
                        report("status", int'(status), int'(want.st));
                    if (rect_x !== want.x)
                        report("rect_x", int'(rect_x), int'(want.x));
                    if (rect_y !== want.y)
                        report("rect_y", int'(rect_y), int'(want.y));
                    if (handle_out !== want.hnd)
                        report("handle_out", int'(handle_out), int'(want.hnd));
                    if (alloc_count !== want.live)
                        report("alloc_count", int'(alloc_count), int'(want.live));
                end
            end
            // requests
            if (in_valid && !in_stall)
                expected_resp.push_back(predict_response(op, int'(req_width),
                                                         int'(req_height),
                                                         int'(handle_in)));
        end
    end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the shelf rectangle allocator: register settings, directed
// corner requests, random allocate/release/clear/no-op traffic with random gaps
// and stalls, and a long output hold-off; checking is done in sra_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sra_pkg::*;

    localparam int  RANDOM_REQS = 1700;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  op = OP_NOP;
    logic [12:0] req_width = '0, req_height = '0;
    logic [5:0]  handle_in = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  status;
    logic [12:0] rect_x, rect_y;
    logic [5:0]  handle_out;
    logic [6:0]  alloc_count;
    int          fail_count, pending, resp_seen;
    longint      cycle_count = 0;
    bit          hold_off = 0;
    int          sent = 0;

    always #4 clk = ~clk;

    shelf_rectangle_allocator_unit dut (.*);

    sra_checker chk (.*);

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall: a random wait before each response, with one long hold-off
    initial
    begin
        int n;
        bit held;
        held = 0;
        forever begin
            if (hold_off && !held) begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                held = 1;
                out_stall <= 0;
            end
            else begin
                n = $urandom_range(0, 11);
                if (n > 0) begin
                    out_stall <= 1;
                    repeat (n) @(posedge clk);
                    out_stall <= 0;
                end
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic send_request(input logic [1:0] o, input int w, input int h,
                                input int hnd, input bit gaps);
        int g;
        if (gaps) begin
            g = $urandom_range(0, 11);
            if ($urandom_range(0, 2) == 0) g = 0;
            if (g > 0) begin
                in_valid <= 0;
                repeat (g) @(posedge clk);
            end
        end
        in_valid <= 1;
        op <= o;
        req_width <= 13'(w);
        req_height <= 13'(h);
        handle_in <= 6'(hnd);
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic int rand_size(input int top);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 8191);
            1:       return top;
            2:       return $urandom_range(0, 3);
            default: return $urandom_range(1, top);
        endcase
    endfunction

    initial
    begin
        int phase_w[4], phase_h[4], phase_m[4];
        int r;
        phase_w = '{4096, 64, 8191, 300};
        phase_h = '{4096, 48, 1, 256};
        phase_m = '{0, 255, 3, 2};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed, reset registers
        send_request(OP_ALLOC, 4096, 4096, 0, 0);
        send_request(OP_ALLOC, 1, 1, 0, 0);
        send_request(OP_RELEASE, 0, 0, 0, 0);
        send_request(OP_RELEASE, 0, 0, 0, 0);
        send_request(OP_RELEASE, 0, 0, 63, 0);
        send_request(OP_NOP, 8191, 8191, 63, 0);
        send_request(OP_CLEAR, 0, 0, 0, 0);
        send_request(OP_ALLOC, 0, 0, 0, 0);
        send_request(OP_ALLOC, 8191, 1, 0, 0);
        send_request(OP_ALLOC, 4000, 100, 0, 0);
        send_request(OP_ALLOC, 200, 50, 0, 0);
        send_request(OP_ALLOC, 50, 10, 0, 0);
        send_request(OP_ALLOC, 4096, 5000, 0, 0);
        // fill the handle table
        for (int i = 0; i < 66; i++)
            send_request(OP_ALLOC, 1, 1, 0, 0);
        // overflow the free list on release
        for (int i = 0; i < 20; i++)
            send_request(OP_RELEASE, 0, 0, i, 0);
        send_request(OP_CLEAR, 0, 0, 0, 0);
        drain();

        // long hold-off while requests keep coming
        hold_off = 1;
        for (int i = 0; i < 12; i++)
            send_request(OP_ALLOC, 10, 10, 0, 0);
        drain();

        // random phases over register settings
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_ATLAS_WIDTH, phase_w[p]);
            write_reg(REG_ATLAS_HEIGHT, phase_h[p]);
            write_reg(REG_GAP_MARGIN, phase_m[p]);
            send_request(OP_CLEAR, 0, 0, 0, 1);
            for (int i = 0; i < RANDOM_REQS / 4; i++) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    send_request(OP_ALLOC, rand_size(phase_w[p] > 4096 ? 4096 : phase_w[p] / 3 + 1),
                                 rand_size(phase_h[p] > 4096 ? 4096 : phase_h[p] / 3 + 1),
                                 $urandom_range(0, 63), 1);
                else if (r < 92)
                    send_request(OP_RELEASE, $urandom_range(0, 8191), $urandom_range(0, 8191),
                                 $urandom_range(0, 63), 1);
                else if (r < 96)
                    send_request(OP_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191),
                                 $urandom_range(0, 63), 1);
                else
                    send_request(OP_NOP, $urandom_range(0, 8191), $urandom_range(0, 8191),
                                 $urandom_range(0, 63), 1);
            end
            drain();
        end

        $display("covered %0d requests, %0d responses, four register settings", sent,
                 resp_seen);
        $display("including table full, free list overflow and a long output hold-off");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
